[hdl/stpr_pkg.sv]
// ----------------------------------------------------------------------------
// stpr_pkg
// shared widths, datapath operation codes and controller/datapath bundles
// ----------------------------------------------------------------------------
package stpr_pkg;

  localparam int IV_W    = 25;
  localparam int CNT_W   = 11;
  localparam int POS_W   = 12;
  localparam int DELTA_W = 12;
  localparam int NUM_W   = 13;
  localparam int PROD_W  = IV_W + NUM_W;
  localparam int K_W     = 4;

  localparam logic [IV_W-1:0] IV_MAX = '1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_TARGET,
    OP_SIM_MUL,
    OP_DIV_START,
    OP_SIM_TAKE,
    OP_SIM_END,
    OP_POS,
    OP_RAMP_PREP,
    OP_RAMP_MUL,
    OP_RAMP_TAKE,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   fin;
    logic   ign;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_zero;
    logic active;
    logic mod_last;
    logic sim_go;
    logic tgt_eq;
    logic div_done;
  } dp_sts_t;

endpackage

[hdl/stepper_trapezoid_ramp.sv]
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// trapezoidal stepper speed ramp with circular position tracking
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+------------------------------
//  in       | sink      | in_valid_i / in_stall_o | req_type, delta
//  out      | source    | out_valid_o / out_stall_i | interval, dir, position, flags
//  apb      | slave     | psel/penable/pready    | start_interval_us, min_interval_us
//
//  one word is taken at a time; in_stall_o is high from acceptance until the
//  result is loaded into the output register
//  a step word runs one pass of the restoring divider
//  a start word runs the modulo reduction, then one divider pass per
//  acceleration step of the planning loop (up to half the move)
//  reset is asynchronous active low; no clearing pass is needed
//  a stalled result holds in the output register while the next word is taken
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp #(
  parameter int REV_STEPS = 3200
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [stpr_pkg::DELTA_W-1:0] delta_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stpr_pkg::IV_W-1:0]           interval_us_o,
  output logic                                backward_o,
  output logic [stpr_pkg::POS_W-1:0]          position_o,
  output logic                                running_o,
  output logic                                finished_o,
  output logic                                ignored_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import stpr_pkg::*;

  localparam logic REG_START = 1'b0;
  localparam logic REG_MIN   = 1'b1;

  logic [IV_W-1:0] start_iv_q, min_iv_q;
  logic            wr_en;
  dp_cmd_t         cmd;
  dp_sts_t         sts;

  // register writes complete in the access phase; pready is tied high
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_iv_q <= IV_W'(10000);
      min_iv_q   <= IV_W'(500);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_START: start_iv_q <= pwdata[IV_W-1:0];
        REG_MIN:   min_iv_q   <= pwdata[IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START: prdata = 32'(start_iv_q);
      REG_MIN:   prdata = 32'(min_iv_q);
      default:   prdata = '0;
    endcase
  end

  // sequencer: plans the ramp on a start, updates it on each step
  stpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // move state, shared multiplier and divider, result register
  stpr_dp #(
    .REV_STEPS (REV_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .delta_i       (delta_i),
    .start_iv_i    (start_iv_q),
    .min_iv_i      (min_iv_q),
    .interval_us_o (interval_us_o),
    .backward_o    (backward_o),
    .position_o    (position_o),
    .running_o     (running_o),
    .finished_o    (finished_o),
    .ignored_o     (ignored_o)
  );

endmodule

[hdl/stpr_div.sv]
// ----------------------------------------------------------------------------
// stpr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stpr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [stpr_pkg::PROD_W-1:0]  dividend_i,
  input  logic [stpr_pkg::NUM_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [stpr_pkg::PROD_W-1:0]  quotient_o
);
  import stpr_pkg::*;

  localparam int CW = $clog2(PROD_W + 1);
  localparam logic [CW-1:0] LAST = CW'(PROD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  dvs_q, dvs_d;
  logic [NUM_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, acc_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? NUM_W'(trial - {1'b0, dvs_q}) : NUM_W'(trial);
      acc_d = {acc_q[PROD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

[hdl/stpr_dp.sv]
// ----------------------------------------------------------------------------
// stpr_dp
// ramp datapath: position, target, interval, multiplier and divider
// ----------------------------------------------------------------------------
module stpr_dp #(
  parameter int REV_STEPS = 3200
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stpr_pkg::dp_cmd_t              cmd_i,
  output stpr_pkg::dp_sts_t              sts_o,
  input  logic                           req_type_i,
  input  logic signed [stpr_pkg::DELTA_W-1:0] delta_i,
  input  logic [stpr_pkg::IV_W-1:0]      start_iv_i,
  input  logic [stpr_pkg::IV_W-1:0]      min_iv_i,
  output logic [stpr_pkg::IV_W-1:0]      interval_us_o,
  output logic                           backward_o,
  output logic [stpr_pkg::POS_W-1:0]     position_o,
  output logic                           running_o,
  output logic                           finished_o,
  output logic                           ignored_o
);
  import stpr_pkg::*;

  localparam int SPR_W = $clog2(REV_STEPS + 1);
  localparam int SH_W  = SPR_W + CNT_W;
  localparam logic [SH_W-1:0]  SPR_SH   = SH_W'(REV_STEPS);
  localparam logic [POS_W:0]   SPR_P    = (POS_W + 1)'(REV_STEPS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(REV_STEPS - 1);
  localparam logic [K_W-1:0]   K_FIRST  = K_W'(CNT_W - 1);

  // item and move state
  logic                     req_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [POS_W-1:0]  cur_q, tgt_q;
  logic              bwd_q, active_q;
  logic [CNT_W-1:0]  total_q, done_q, accel_q, bstart_q, bleft_q, n_q, rem_q;
  logic [K_W-1:0]    k_q;
  logic [IV_W-1:0]   ival_q, sim_q;
  logic [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  den_q;

  logic              neg;
  logic [DELTA_W-1:0] abs_w;
  logic [CNT_W-1:0]  mag;
  logic [SH_W-1:0]   sub_w, rem_ext;
  logic [POS_W:0]    fwd_sum, bwd_add, tgt_w;
  logic [POS_W-1:0]  pos_next;
  logic [CNT_W-1:0]  n_inc, done_inc;
  logic [IV_W-1:0]   mul_a;
  logic [NUM_W-1:0]  mul_num, mul_den;
  logic [PROD_W-1:0] quo;
  logic [IV_W-1:0]   quo_sat;
  logic              div_done;
  logic [IV_W-1:0]   iv_first;

  stpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_START),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign neg   = delta_q[DELTA_W-1];
  assign abs_w = neg ? DELTA_W'(~delta_q + 1'b1) : DELTA_W'(delta_q);
  assign mag   = abs_w[DELTA_W-1] ? '1 : abs_w[CNT_W-1:0];

  assign sub_w   = SPR_SH << k_q;
  assign rem_ext = SH_W'(rem_q);

  assign fwd_sum = {1'b0, cur_q} + (POS_W + 1)'(rem_q);
  assign bwd_add = {1'b0, cur_q} + SPR_P - (POS_W + 1)'(rem_q);
  always_comb begin
    if (!neg) tgt_w = (fwd_sum >= SPR_P) ? fwd_sum - SPR_P : fwd_sum;
    else      tgt_w = ({1'b0, cur_q} >= (POS_W + 1)'(rem_q)) ?
                      {1'b0, cur_q} - (POS_W + 1)'(rem_q) : bwd_add;
  end

  always_comb begin
    if (bwd_q) pos_next = (cur_q == '0) ? POS_LAST : cur_q - 1'b1;
    else       pos_next = (cur_q == POS_LAST) ? '0 : cur_q + 1'b1;
  end

  assign n_inc    = n_q + 1'b1;
  assign done_inc = done_q + 1'b1;
  assign iv_first = (start_iv_i > min_iv_i) ? start_iv_i : min_iv_i;

  // accelerate: (4n-1)/(4n+1), brake: (4b+1)/(4b-1)
  always_comb begin
    mul_a = ival_q;
    if (cmd_i.op == OP_SIM_MUL) begin
      mul_a   = sim_q;
      mul_num = {n_inc, 2'b00} - 1'b1;
      mul_den = {n_inc, 2'b00} + 1'b1;
    end else if (bleft_q != '0) begin
      mul_num = {bleft_q, 2'b00} + 1'b1;
      mul_den = {bleft_q, 2'b00} - 1'b1;
    end else begin
      mul_num = {done_q, 2'b00} - 1'b1;
      mul_den = {done_q, 2'b00} + 1'b1;
    end
  end

  assign quo_sat = (quo[PROD_W-1:IV_W] != '0) ? IV_MAX : quo[IV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      tgt_q    <= '0;
      bwd_q    <= 1'b0;
      active_q <= 1'b0;
      total_q  <= '0;
      done_q   <= '0;
      accel_q  <= '0;
      bstart_q <= '0;
      bleft_q  <= '0;
      ival_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_TARGET: begin
          tgt_q   <= tgt_w[POS_W-1:0];
          bwd_q   <= neg;
          total_q <= mag;
          done_q  <= '0;
          ival_q  <= iv_first;
        end
        OP_SIM_END: begin
          accel_q  <= (n_q == '0) ? CNT_W'(1) : n_q;
          bstart_q <= total_q - ((n_q == '0) ? CNT_W'(1) : n_q);
          bleft_q  <= '0;
          active_q <= tgt_q != cur_q;
        end
        OP_POS: begin
          cur_q <= pos_next;
          if (pos_next == tgt_q) active_q <= 1'b0;
        end
        OP_RAMP_PREP: begin
          done_q <= done_inc;
          if (bleft_q == '0 && done_inc >= bstart_q) bleft_q <= accel_q;
        end
        OP_RAMP_TAKE: begin
          if (bleft_q != '0) begin
            ival_q  <= quo_sat;
            bleft_q <= bleft_q - 1'b1;
          end else begin
            ival_q <= (quo_sat < min_iv_i) ? min_iv_i : quo_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // per-item scratch and result word
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q   <= req_type_i;
        delta_q <= delta_i;
      end
      OP_MOD_INIT: begin
        rem_q <= mag;
        k_q   <= K_FIRST;
      end
      OP_MOD_STEP: begin
        if (rem_ext >= sub_w) rem_q <= CNT_W'(rem_ext - sub_w);
        k_q <= k_q - 1'b1;
      end
      OP_TARGET: begin
        sim_q <= iv_first;
        n_q   <= '0;
      end
      OP_SIM_MUL: begin
        n_q    <= n_inc;
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_num);
        den_q  <= mul_den;
      end
      OP_RAMP_MUL: begin
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_num);
        den_q  <= mul_den;
      end
      OP_SIM_TAKE: sim_q <= quo_sat;
      OP_RESULT: begin
        interval_us_o <= ival_q;
        backward_o    <= bwd_q;
        position_o    <= cur_q;
        running_o     <= active_q;
        finished_o    <= cmd_i.fin;
        ignored_o     <= cmd_i.ign;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.is_start = !req_q;
    sts_o.is_zero  = delta_q == '0;
    sts_o.active   = active_q;
    sts_o.mod_last = k_q == '0;
    sts_o.sim_go   = (sim_q > min_iv_i) && (n_q < (total_q >> 1));
    sts_o.tgt_eq   = tgt_q == cur_q;
    sts_o.div_done = div_done;
  end

endmodule

[hdl/stpr_ctrl.sv]
// ----------------------------------------------------------------------------
// stpr_ctrl
// sequencer for start planning and per-step ramp update
// ----------------------------------------------------------------------------
module stpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stpr_pkg::dp_cmd_t  cmd_o,
  input  stpr_pkg::dp_sts_t  sts_i
);
  import stpr_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_TGT     = 4'd3;
  localparam logic [3:0] S_SIMCHK  = 4'd4;
  localparam logic [3:0] S_SIMDIV0 = 4'd5;
  localparam logic [3:0] S_SIMDIV  = 4'd6;
  localparam logic [3:0] S_SIMEND  = 4'd7;
  localparam logic [3:0] S_POSCHK  = 4'd8;
  localparam logic [3:0] S_RMUL    = 4'd9;
  localparam logic [3:0] S_RDIV0   = 4'd10;
  localparam logic [3:0] S_RDIV    = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  logic [3:0] state_q, state_d;
  logic       fin_q, fin_d, ign_q, ign_d;
  logic       ovld_q, ovld_d;

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    ign_d     = ign_q;
    ovld_d    = ovld_q && out_stall_i;
    cmd_o.op  = OP_NONE;
    cmd_o.fin = fin_q;
    cmd_o.ign = ign_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        fin_d = 1'b0;
        ign_d = 1'b0;
        if (sts_i.is_start) begin
          if (sts_i.is_zero || sts_i.active) begin
            ign_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.op = OP_MOD_INIT;
            state_d  = S_MOD;
          end
        end else if (!sts_i.active) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_POS;
          state_d  = S_POSCHK;
        end
      end
      S_MOD: begin
        cmd_o.op = OP_MOD_STEP;
        if (sts_i.mod_last) state_d = S_TGT;
      end
      S_TGT: begin
        cmd_o.op = OP_TARGET;
        state_d  = S_SIMCHK;
      end
      S_SIMCHK: begin
        if (sts_i.sim_go) begin
          cmd_o.op = OP_SIM_MUL;
          state_d  = S_SIMDIV0;
        end else begin
          state_d = S_SIMEND;
        end
      end
      S_SIMDIV0: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_SIMDIV;
      end
      S_SIMDIV: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_SIM_TAKE;
          state_d  = S_SIMCHK;
        end
      end
      S_SIMEND: begin
        cmd_o.op = OP_SIM_END;
        fin_d    = sts_i.tgt_eq;
        state_d  = S_OUT;
      end
      S_POSCHK: begin
        if (!sts_i.active) begin
          fin_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_RAMP_PREP;
          state_d  = S_RMUL;
        end
      end
      S_RMUL: begin
        cmd_o.op = OP_RAMP_MUL;
        state_d  = S_RDIV0;
      end
      S_RDIV0: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_RDIV;
      end
      S_RDIV: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_RAMP_TAKE;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!(ovld_q && out_stall_i)) begin
          cmd_o.op = OP_RESULT;
          ovld_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      ign_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      ign_q   <= ign_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = ovld_q;

endmodule

[bench/tb_stepper_trapezoid_ramp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_trapezoid_ramp
// self-checking bench for the trapezoidal stepper speed ramp
// ----------------------------------------------------------------------------
// a bit-exact ramp planner in the bench follows every accepted word and keeps
// the expected result words in order; a checker process compares each result
// word field by field; moves are mostly short, well-formed start/step runs,
// with ignored starts, idle steps and a few long moves mixed in; several
// interval settings are used, extremes included, with random idling on both
// sides and one long receiver hold-off that backs the block up
// ----------------------------------------------------------------------------
module tb_stepper_trapezoid_ramp;
  import stpr_pkg::*;

  localparam int REV_STEPS = 3200;
  localparam int CNT_MAX   = 2047;
  localparam int IV_TOP    = 33554431;

  // register byte addresses
  localparam logic [2:0] ADDR_START_IV = 3'd0;
  localparam logic [2:0] ADDR_MIN_IV   = 3'd4;

  typedef enum logic {REQ_START = 1'b0, REQ_STEP = 1'b1} req_e;

  typedef struct {
    logic [IV_W-1:0]  interval;
    logic             backward;
    logic [POS_W-1:0] position;
    logic             running;
    logic             finished;
    logic             ignored;
  } ramp_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input word channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = 1'b0;
  logic [DELTA_W-1:0] delta = '0;

  // result word channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IV_W-1:0]  interval_us;
  logic             backward;
  logic [POS_W-1:0] position;
  logic             running;
  logic             finished;
  logic             ignored;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stepper_trapezoid_ramp #(.REV_STEPS(REV_STEPS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .delta_i(delta),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .interval_us_o(interval_us), .backward_o(backward), .position_o(position),
    .running_o(running), .finished_o(finished), .ignored_o(ignored),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle percentages and the long hold-off counter of the receiver
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rcv_hold_cycles = 0;
  int err_cnt = 0;

  ramp_word_t expected_words[$];

  // planner copy of the configuration
  logic [IV_W-1:0] cfg_start_iv = 25'd10000;
  logic [IV_W-1:0] cfg_min_iv   = 25'd500;

  // planner copy of the ramp state
  logic [POS_W-1:0] cur_pos = '0;
  logic [POS_W-1:0] tgt_pos = '0;
  logic             dir_bwd = 1'b0;
  logic             mv_active = 1'b0;
  logic [CNT_W-1:0] steps_total = '0;
  logic [CNT_W-1:0] steps_done = '0;
  logic [CNT_W-1:0] accel_steps = '0;
  logic [CNT_W-1:0] brake_start = '0;
  logic [CNT_W-1:0] brake_left = '0;
  logic [IV_W-1:0]  cur_iv = '0;

  // c * num / den rounded down, saturated to the interval width
  function automatic logic [IV_W-1:0] ratio_floor(logic [IV_W-1:0] c,
                                                  int unsigned num, int unsigned den);
    longint unsigned v;
    v = (longint'(c) * longint'(num)) / longint'(den);
    return (v > longint'(IV_TOP)) ? IV_MAX : v[IV_W-1:0];
  endfunction

  // advance the planner by one accepted word and queue its result word
  task automatic plan_word(logic rq, logic [DELTA_W-1:0] d);
    ramp_word_t w;
    int sd;
    int mag;
    int tgt;
    int unsigned half;
    int unsigned n;
    logic [IV_W-1:0] sim;
    logic fin;
    logic ign;
    fin = 1'b0;
    ign = 1'b0;
    sd = $signed(d);
    if (rq == REQ_START) begin
      if (sd == 0 || mv_active) begin
        ign = 1'b1;
      end else begin
        mag = (sd < 0) ? -sd : sd;
        // -2048 does not fit the step counter, clamp to 2047 steps
        if (mag > CNT_MAX) begin
          mag = CNT_MAX;
          sd = (sd < 0) ? -CNT_MAX : CNT_MAX;
        end
        steps_total = CNT_W'(mag);
        steps_done = '0;
        tgt = (int'(cur_pos) + sd) % REV_STEPS;
        if (tgt < 0) tgt += REV_STEPS;
        tgt_pos = POS_W'(tgt);
        dir_bwd = (sd < 0);
        cur_iv = (cfg_start_iv > cfg_min_iv) ? cfg_start_iv : cfg_min_iv;
        // find the acceleration length, at most half the move
        half = steps_total / 2;
        sim = cur_iv;
        n = 0;
        while (sim > cfg_min_iv && n < half) begin
          n++;
          sim = ratio_floor(sim, 4 * n - 1, 4 * n + 1);
          if (sim < cfg_min_iv) break;
        end
        if (n == 0) n = 1;
        accel_steps = CNT_W'(n);
        brake_start = steps_total - accel_steps;
        brake_left = '0;
        mv_active = (tgt_pos != cur_pos);
        fin = !mv_active;
      end
    end else if (mv_active) begin
      if (dir_bwd)
        cur_pos = (cur_pos == 0) ? POS_W'(REV_STEPS - 1) : cur_pos - 1'b1;
      else
        cur_pos = (int'(cur_pos) + 1 >= REV_STEPS) ? '0 : cur_pos + 1'b1;
      if (cur_pos == tgt_pos) begin
        // final step keeps the last interval
        mv_active = 1'b0;
        fin = 1'b1;
      end else begin
        steps_done = steps_done + 1'b1;
        if (brake_left == 0 && steps_done >= brake_start) brake_left = accel_steps;
        if (brake_left > 0) begin
          cur_iv = ratio_floor(cur_iv, 4 * brake_left + 1, 4 * brake_left - 1);
          brake_left = brake_left - 1'b1;
        end else begin
          cur_iv = ratio_floor(cur_iv, 4 * steps_done - 1, 4 * steps_done + 1);
          if (cur_iv < cfg_min_iv) cur_iv = cfg_min_iv;
        end
      end
    end
    w.interval = cur_iv;
    w.backward = dir_bwd;
    w.position = cur_pos;
    w.running  = mv_active;
    w.finished = fin;
    w.ignored  = ign;
    expected_words.push_back(w);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // result word checker and receiver stall generator
  always @(posedge clk) begin
    ramp_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = expected_words.pop_front();
        if (interval_us !== w.interval) report_mismatch("interval_us", interval_us, w.interval);
        if (backward !== w.backward) report_mismatch("backward", backward, w.backward);
        if (position !== w.position) report_mismatch("position", position, w.position);
        if (running !== w.running) report_mismatch("running", running, w.running);
        if (finished !== w.finished) report_mismatch("finished", finished, w.finished);
        if (ignored !== w.ignored) report_mismatch("ignored", ignored, w.ignored);
      end
    end
    if (rcv_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rcv_hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(logic rq, logic [DELTA_W-1:0] d);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    delta <= d;
    do @(posedge clk); while (in_stall);
    plan_word(rq, d);
  endtask

  // drop valid and wait until every expected word is back
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic reg_write(logic [2:0] addr, logic [IV_W-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[IV_W-1:0] !== value) report_mismatch("register readback", prdata, value);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_START_IV) cfg_start_iv = value;
    else cfg_min_iv = value;
  endtask

  task automatic set_intervals(logic [IV_W-1:0] start_iv, logic [IV_W-1:0] min_iv);
    drain();
    reg_write(ADDR_START_IV, start_iv);
    reg_write(ADDR_MIN_IV, min_iv);
  endtask

  // run one move from start word to its final step
  task automatic run_move(int d);
    send_word(REQ_START, DELTA_W'(d));
    while (mv_active) begin
      // an occasional start while running must be ignored
      if ($urandom_range(99) < 3) send_word(REQ_START, DELTA_W'($urandom));
      else send_word(REQ_STEP, DELTA_W'($urandom));
    end
  endtask

  task automatic test_directed;
    send_word(REQ_STEP, '0);              // step while idle
    send_word(REQ_START, '0);             // zero move
    send_word(REQ_START, DELTA_W'(6));
    send_word(REQ_START, DELTA_W'(3));    // start while running
    while (mv_active) send_word(REQ_STEP, '1);
    run_move(-9);                         // wraps backward past zero
    run_move(1);
    run_move(-1);
    run_move(2);
  endtask

  // full-scale start, clamped to 2047 steps; the move stays open at the end
  task automatic test_extreme_deltas;
    set_intervals(25'd500, 25'd500);
    send_word(REQ_START, DELTA_W'(-2048));
    repeat (24) send_word(REQ_STEP, '0);
  endtask

  task automatic test_random_moves(int n_words);
    int d;
    for (int sent = 0; sent < n_words; ) begin
      case ($urandom_range(19))
        0: begin
          send_word(REQ_STEP, DELTA_W'($urandom));   // idle step noise
          sent++;
        end
        1: begin
          d = $signed(DELTA_W'($urandom));           // any 12-bit value
          if (d > 300 || d < -300) d = d / 8;
          run_move(d);
          sent += (d < 0 ? -d : d) + 1;
        end
        2: begin
          d = $urandom_range(100, 1600);
          if ($urandom_range(1)) d = -d;
          if ($urandom_range(9) == 0) begin
            run_move(d);
            sent += (d < 0 ? -d : d) + 1;
          end
        end
        default: begin
          d = $urandom_range(1, 40);
          if ($urandom_range(1)) d = -d;
          run_move(d);
          sent += (d < 0 ? -d : d) + 1;
        end
      endcase
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure;
    rcv_hold_cycles = 600;
    for (int i = 0; i < 6; i++) run_move($urandom_range(2, 5));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles little, receiver often, then swapped, then neither
    snd_idle_pct = 27;
    rcv_idle_pct = 79;
    test_directed();
    test_random_moves(250);
    set_intervals(25'(IV_TOP), 25'd1);     // largest start, smallest minimum
    test_random_moves(200);

    snd_idle_pct = 79;
    rcv_idle_pct = 27;
    set_intervals(25'd1, 25'(IV_TOP));     // start below the minimum
    test_random_moves(200);
    set_intervals('0, '0);                 // zero registers
    test_random_moves(200);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    set_intervals(25'(IV_TOP), 25'(IV_TOP));
    test_random_moves(150);
    set_intervals(25'($urandom_range(1000, 200000)), 25'($urandom_range(1, 5000)));
    test_random_moves(300);
    set_intervals(25'd10000, 25'd500);
    test_random_moves(250);
    test_extreme_deltas();

    drain();
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
